// ----- rtl/wav_pcm16_stream_parser_macros.svh -----
// ---------------------------------------------------------------------------
// WAV PCM16 stream parser assertion macros
// Shorthand for the concurrent checks used in the parser RTL.
// ---------------------------------------------------------------------------
`ifndef WAV_PCM16_STREAM_PARSER_MACROS_SVH
`define WAV_PCM16_STREAM_PARSER_MACROS_SVH

// same-cycle implication
`define WPS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wav parser check failed");

// next-cycle implication
`define WPS_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wav parser check failed");

`endif

// ----- rtl/wps_pkg.sv -----
// ---------------------------------------------------------------------------
// WAV PCM16 stream parser package
// Phase codes, result codes, chunk tags, register defaults and result type.
// ---------------------------------------------------------------------------
package wps_pkg;

    typedef enum logic [2:0] {
        PH_RIFF,
        PH_HDR,
        PH_FMT,
        PH_SKIP,
        PH_PCM,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        CFG_MAX_CHUNKS,
        CFG_MIN_RATE,
        CFG_MAX_RATE
    } t_cfg_idx;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [1:0] ERR_HDR_INVALID = 2'd0;
    localparam logic [1:0] ERR_FORMAT      = 2'd1;
    localparam logic [1:0] ERR_RATE        = 2'd2;
    localparam logic [1:0] ERR_NO_PCM      = 2'd3;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [15:0] FMT_PCM    = 16'd1;
    localparam logic [15:0] PCM_BITS   = 16'd16;
    localparam logic [31:0] FMT_MIN_SZ = 32'd16;

    localparam logic [7:0]  MAX_CHUNKS_RST = 8'd64;
    localparam logic [17:0] MIN_RATE_RST   = 18'd8000;
    localparam logic [17:0] MAX_RATE_RST   = 18'd96000;

    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  code;
        logic [15:0] sample;
        logic [17:0] rate;
        logic [1:0]  chans;
        logic [31:0] size;
        logic        last;
    } t_result;

    typedef struct packed {
        logic       fail;
        logic [1:0] fail_code;
        logic       hdr_ok;
        logic       sample;
        logic       finish;
        logic       chunk_done;
        logic       to_hdr;
        logic       to_fmt;
        logic       to_skip;
        logic       to_pcm;
    } t_dec;

endpackage

// ----- rtl/wav_pcm16_stream_parser.sv -----
// ---------------------------------------------------------------------------
// WAV PCM16 stream parser
// Byte-wide RIFF/WAVE header walker with PCM16 mono mixdown.
// ---------------------------------------------------------------------------
// One file byte is taken per clock while o_stall is low. Header checks, chunk
// walking and frame assembly are done in the cycle the byte is accepted, and
// the results land in a four-entry result queue. A byte yields at most two
// results (header plus an immediate end, or a last frame plus its end); the
// queue drains one result per cycle while i_stall is low. o_stall rises when
// fewer than two queue entries are free. Configuration registers are kept
// across end markers.
`include "wav_pcm16_stream_parser_macros.svh"

module wav_pcm16_stream_parser
    import wps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_end_marker,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_kind,
    output logic [1:0]         o_error_code,
    output logic signed [15:0] o_left_sample,
    output logic signed [15:0] o_right_sample,
    output logic [17:0]        o_sample_rate,
    output logic [1:0]         o_channels,
    output logic [31:0]        o_data_size,
    output logic               o_last_of_run,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [17:0]        i_cfg_data
);

    logic [7:0]  r_max_chunks;
    logic [17:0] r_min_rate;
    logic [17:0] r_max_rate;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_bc, n_bc;
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_len, n_len;
    logic [7:0]  r_cs, n_cs;
    logic        r_fmt_seen, n_fmt_seen;
    logic [15:0] r_afmt, n_afmt;
    logic [15:0] r_ch, n_ch;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_bits, n_bits;
    logic [31:0] r_dl, n_dl;
    logic [23:0] r_fbytes, n_fbytes;
    logic [1:0]  r_pos, n_pos;
    logic        r_played, n_played;
    logic        r_pad, n_pad;

    t_result     r_rq [RQ_DEPTH];
    logic [RQ_AW-1:0] r_wr, r_rd;
    logic [RQ_AW:0]   r_count;

    logic        acc_in, pop;
    t_dec        dec;
    t_result     res0, res1;
    logic [1:0]  n_push;

    logic [31:0] sz;
    logic [7:0]  cs_inc;
    logic        cd_fail;
    logic [2:0]  fb;
    logic        frame_full;
    logic [31:0] dl_dec;
    logic [31:0] skip_len;
    logic        skip_pad;
    logic [15:0] mix;
    logic [15:0] smp_l, smp_r;
    logic [16:0] sum;

    assign acc_in  = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;
    assign o_stall = r_count > (RQ_AW+1)'(RQ_DEPTH - 2);
    assign o_valid = r_count != '0;

    // shared values
    assign sz         = {i_data_byte, r_len[23:0]};
    assign cs_inc     = (r_cs == 8'hFF) ? r_cs : 8'(r_cs + 8'd1);
    assign cd_fail    = cs_inc >= r_max_chunks;
    assign fb         = (r_ch == 16'd1) ? 3'd2 : 3'd4;
    assign frame_full = ({1'b0, r_pos} + 3'd1) == fb;
    assign dl_dec     = r_dl - 32'd1;
    assign skip_len   = (r_len != '0) ? (r_len - 32'd1) : r_len;
    assign skip_pad   = (r_len != '0) ? r_pad : 1'b0;
    assign smp_l      = r_fbytes[15:0];
    assign smp_r      = {i_data_byte, r_fbytes[23:16]};
    assign sum        = {1'b0, smp_l ^ 16'h8000} + {1'b0, smp_r ^ 16'h8000};
    assign mix        = (fb == 3'd2) ? {i_data_byte, r_fbytes[7:0]}
                                     : (sum[16:1] ^ 16'h8000);

    // decisions for the accepted item
    always_comb begin
        dec = '0;
        if (acc_in) begin
            if (i_end_marker) begin
                if (r_phase == PH_PCM) begin
                    dec.finish = 1'b1;
                end else if (r_phase != PH_DONE) begin
                    dec.fail      = 1'b1;
                    dec.fail_code = ERR_HDR_INVALID;
                end
            end else begin
                case (r_phase)
                    PH_RIFF: begin
                        if (r_bc == 5'd11) begin
                            if (r_tag != TAG_RIFF || sz != TAG_WAVE || r_max_chunks == '0) begin
                                dec.fail = 1'b1;
                            end else begin
                                dec.to_hdr = 1'b1;
                            end
                        end
                    end
                    PH_HDR: begin
                        if (r_bc == 5'd7) begin
                            if (r_tag == TAG_FMT) begin
                                if (sz < FMT_MIN_SZ) dec.fail = 1'b1;
                                else dec.to_fmt = 1'b1;
                            end else if (r_tag == TAG_DATA) begin
                                if (!r_fmt_seen) begin
                                    dec.fail = 1'b1;
                                end else if (r_afmt != FMT_PCM || r_bits != PCM_BITS ||
                                             !(r_ch inside {16'd1, 16'd2})) begin
                                    dec.fail      = 1'b1;
                                    dec.fail_code = ERR_FORMAT;
                                end else if (r_rate < {14'd0, r_min_rate} ||
                                             r_rate > {14'd0, r_max_rate}) begin
                                    dec.fail      = 1'b1;
                                    dec.fail_code = ERR_RATE;
                                end else begin
                                    dec.hdr_ok = 1'b1;
                                    dec.to_pcm = 1'b1;
                                    dec.finish = sz < {29'd0, fb};
                                end
                            end else if (sz == '0) begin
                                dec.chunk_done = 1'b1;
                            end else begin
                                dec.to_skip = 1'b1;
                            end
                        end
                    end
                    PH_FMT: begin
                        if (r_bc == 5'd15) begin
                            if (r_len == '0 && !r_pad) dec.chunk_done = 1'b1;
                            else dec.to_skip = 1'b1;
                        end
                    end
                    PH_SKIP: begin
                        if (skip_len == '0 && !skip_pad) dec.chunk_done = 1'b1;
                    end
                    PH_PCM: begin
                        if (frame_full) begin
                            dec.sample = 1'b1;
                            dec.finish = dl_dec < {29'd0, fb};
                        end
                    end
                    default: begin
                    end
                endcase
                if (dec.chunk_done) begin
                    if (cd_fail) dec.fail = 1'b1;
                    else dec.to_hdr = 1'b1;
                end
            end
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (acc_in) begin
            if (i_end_marker) n_phase = PH_RIFF;
            else if (dec.fail || dec.finish) n_phase = PH_DONE;
            else if (dec.to_pcm) n_phase = PH_PCM;
            else if (dec.to_fmt) n_phase = PH_FMT;
            else if (dec.to_skip) n_phase = PH_SKIP;
            else if (dec.to_hdr) n_phase = PH_HDR;
        end
    end

    // results
    always_comb begin
        t_result r_hdr, r_smp, r_err, r_fin;
        r_hdr       = '0;
        r_hdr.kind  = KIND_HEADER;
        r_hdr.rate  = r_rate[17:0];
        r_hdr.chans = r_ch[1:0];
        r_hdr.size  = sz;
        r_smp        = '0;
        r_smp.kind   = KIND_SAMPLE;
        r_smp.sample = mix;
        r_err      = '0;
        r_err.kind = KIND_ERROR;
        r_err.code = dec.fail_code;
        r_fin      = '0;
        if (dec.sample || r_played) begin
            r_fin.kind = KIND_END;
        end else begin
            r_fin.kind = KIND_ERROR;
            r_fin.code = ERR_NO_PCM;
        end
        res1   = r_fin;
        n_push = 2'd0;
        if (dec.hdr_ok) res0 = r_hdr;
        else if (dec.sample) res0 = r_smp;
        else if (dec.fail) res0 = r_err;
        else res0 = r_fin;
        if (dec.hdr_ok || dec.sample || dec.fail || dec.finish) n_push = 2'd1;
        if ((dec.hdr_ok || dec.sample) && dec.finish) n_push = 2'd2;
        res0.last = n_push == 2'd1;
        res1.last = 1'b1;
    end

    // datapath next values
    always_comb begin
        n_bc       = r_bc;
        n_tag      = r_tag;
        n_len      = r_len;
        n_cs       = r_cs;
        n_fmt_seen = r_fmt_seen;
        n_afmt     = r_afmt;
        n_ch       = r_ch;
        n_rate     = r_rate;
        n_bits     = r_bits;
        n_dl       = r_dl;
        n_fbytes   = r_fbytes;
        n_pos      = r_pos;
        n_played   = r_played;
        n_pad      = r_pad;
        if (acc_in) begin
            if (i_end_marker) begin
                n_bc       = '0;
                n_tag      = '0;
                n_len      = '0;
                n_cs       = '0;
                n_fmt_seen = 1'b0;
                n_afmt     = '0;
                n_ch       = '0;
                n_rate     = '0;
                n_bits     = '0;
                n_dl       = '0;
                n_fbytes   = '0;
                n_pos      = '0;
                n_played   = 1'b0;
                n_pad      = 1'b0;
            end else begin
                case (r_phase)
                    PH_RIFF: begin
                        if (r_bc < 5'd4) n_tag[8*r_bc[1:0] +: 8] = i_data_byte;
                        else if (r_bc >= 5'd8) n_len[8*r_bc[1:0] +: 8] = i_data_byte;
                        n_bc = 5'(r_bc + 5'd1);
                    end
                    PH_HDR: begin
                        if (r_bc == 5'd0) begin
                            n_tag = '0;
                            n_len = '0;
                        end
                        if (r_bc < 5'd4) n_tag[8*r_bc[1:0] +: 8] = i_data_byte;
                        else n_len[8*r_bc[1:0] +: 8] = i_data_byte;
                        n_bc = 5'(r_bc + 5'd1);
                        if (r_bc == 5'd7) begin
                            n_pad = sz[0];
                            if (dec.to_fmt) begin
                                n_len = sz - FMT_MIN_SZ;
                                n_bc  = '0;
                            end
                            if (dec.to_pcm) begin
                                n_dl     = sz;
                                n_pos    = '0;
                                n_fbytes = '0;
                            end
                        end
                    end
                    PH_FMT: begin
                        case (r_bc)
                            5'd0:  n_afmt = {8'd0, i_data_byte};
                            5'd1:  n_afmt[15:8] = i_data_byte;
                            5'd2:  n_ch = {8'd0, i_data_byte};
                            5'd3:  n_ch[15:8] = i_data_byte;
                            5'd4:  n_rate = {24'd0, i_data_byte};
                            5'd5:  n_rate[15:8] = i_data_byte;
                            5'd6:  n_rate[23:16] = i_data_byte;
                            5'd7:  n_rate[31:24] = i_data_byte;
                            5'd14: n_bits = {8'd0, i_data_byte};
                            5'd15: n_bits[15:8] = i_data_byte;
                            default: begin
                            end
                        endcase
                        n_bc = 5'(r_bc + 5'd1);
                        if (r_bc == 5'd15) n_fmt_seen = 1'b1;
                    end
                    PH_SKIP: begin
                        n_len = skip_len;
                        n_pad = skip_pad;
                    end
                    PH_PCM: begin
                        n_dl = dl_dec;
                        if (frame_full) begin
                            n_played = 1'b1;
                            n_pos    = '0;
                            n_fbytes = '0;
                        end else begin
                            n_fbytes[8*r_pos +: 8] = i_data_byte;
                            n_pos = 2'(r_pos + 2'd1);
                        end
                    end
                    default: begin
                    end
                endcase
                if (dec.to_hdr) n_bc = '0;
                if (dec.chunk_done) n_cs = cs_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_chunks <= MAX_CHUNKS_RST;
            r_min_rate   <= MIN_RATE_RST;
            r_max_rate   <= MAX_RATE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_CHUNKS: r_max_chunks <= i_cfg_data[7:0];
                CFG_MIN_RATE:   r_min_rate   <= i_cfg_data;
                CFG_MAX_RATE:   r_max_rate   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_RIFF;
            r_bc       <= '0;
            r_tag      <= '0;
            r_len      <= '0;
            r_cs       <= '0;
            r_fmt_seen <= 1'b0;
            r_afmt     <= '0;
            r_ch       <= '0;
            r_rate     <= '0;
            r_bits     <= '0;
            r_dl       <= '0;
            r_fbytes   <= '0;
            r_pos      <= '0;
            r_played   <= 1'b0;
            r_pad      <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_bc       <= n_bc;
            r_tag      <= n_tag;
            r_len      <= n_len;
            r_cs       <= n_cs;
            r_fmt_seen <= n_fmt_seen;
            r_afmt     <= n_afmt;
            r_ch       <= n_ch;
            r_rate     <= n_rate;
            r_bits     <= n_bits;
            r_dl       <= n_dl;
            r_fbytes   <= n_fbytes;
            r_pos      <= n_pos;
            r_played   <= n_played;
            r_pad      <= n_pad;
        end
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) r_rq[r_wr] <= res0;
        if (n_push == 2'd2) r_rq[RQ_AW'(r_wr + 1'b1)] <= res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= RQ_AW'(r_wr + n_push);
            r_rd    <= RQ_AW'(r_rd + pop);
            r_count <= (RQ_AW+1)'(r_count + n_push - pop);
        end
    end

    assign o_kind         = r_rq[r_rd].kind;
    assign o_error_code   = r_rq[r_rd].code;
    assign o_left_sample  = r_rq[r_rd].sample;
    assign o_right_sample = r_rq[r_rd].sample;
    assign o_sample_rate  = r_rq[r_rd].rate;
    assign o_channels     = r_rq[r_rd].chans;
    assign o_data_size    = r_rq[r_rd].size;
    assign o_last_of_run  = r_rq[r_rd].last;

    `WPS_ASSERT_IMP(a_rq_bound, i_clk, i_rst_n, 1'b1, r_count <= (RQ_AW+1)'(RQ_DEPTH))
    `WPS_ASSERT_NXT(a_done_silent, i_clk, i_rst_n, acc_in && r_phase == PH_DONE && !i_end_marker, r_count <= $past(r_count))
    `WPS_ASSERT_NXT(a_hdr_to_pcm, i_clk, i_rst_n, dec.hdr_ok, r_phase == PH_PCM || r_phase == PH_DONE)
    `WPS_ASSERT_NXT(a_end_restart, i_clk, i_rst_n, acc_in && i_end_marker, r_phase == PH_RIFF && r_cs == 8'd0)
    `WPS_ASSERT_IMP(a_sample_kind, i_clk, i_rst_n, o_valid && o_kind != KIND_SAMPLE, o_left_sample == 16'sd0)

endmodule
